>>> rtl/ahtm_pkg.sv
package ahtm_pkg;

    localparam int DEF_NUM_BUCKETS = 8;

    localparam int REQ_W    = 2;
    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 8;
    localparam int SHIFT_W  = 5;
    localparam int SPAN_W   = 3;

    localparam logic [SHIFT_W-1:0] MAX_SHIFT = 5'd31;

    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // reciprocal scale for the threshold divide
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = 17;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_FIT,
        S_UP_A,
        S_UP_B,
        S_UP_W,
        S_LO_A,
        S_LO_B,
        S_LO_W,
        S_FIN,
        S_TOT,
        S_TH,
        S_ST,
        S_EN,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic clr_all;
        logic clr_rng;
    } t_store_ctl;

endpackage

>>> rtl/ahtm_bucket_store.sv
module ahtm_bucket_store #(
    parameter int NUM_BUCKETS = ahtm_pkg::DEF_NUM_BUCKETS,
    parameter int IW          = $clog2(NUM_BUCKETS),
    parameter int EW          = $clog2(NUM_BUCKETS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ahtm_pkg::t_store_ctl         i_ctl,
    input  logic [IW-1:0]                i_rd_idx,
    output logic [ahtm_pkg::SUM_W-1:0]   o_rd_sum,
    output logic [ahtm_pkg::CNT_W-1:0]   o_rd_cnt,
    input  logic [IW-1:0]                i_wr_idx,
    input  logic [ahtm_pkg::SUM_W-1:0]   i_wr_sum,
    input  logic [ahtm_pkg::CNT_W-1:0]   i_wr_cnt,
    input  logic [EW-1:0]                i_clr_lo,
    input  logic [EW-1:0]                i_clr_hi
);

    logic [ahtm_pkg::SUM_W-1:0] r_sum [NUM_BUCKETS];
    logic [ahtm_pkg::CNT_W-1:0] r_cnt [NUM_BUCKETS];

    assign o_rd_sum = r_sum[i_rd_idx];
    assign o_rd_cnt = r_cnt[i_rd_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_BUCKETS; k++) begin
                r_sum[k] <= '0;
                r_cnt[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_BUCKETS; k++) begin
                if (i_ctl.clr_all ||
                    (i_ctl.clr_rng && (EW'(k) >= i_clr_lo) && (EW'(k) < i_clr_hi))) begin
                    r_sum[k] <= '0;
                    r_cnt[k] <= '0;
                end else if (i_ctl.wr_en && (i_wr_idx == IW'(k))) begin
                    r_sum[k] <= i_wr_sum;
                    r_cnt[k] <= i_wr_cnt;
                end
            end
        end
    end

endmodule

>>> rtl/adaptive_histogram_trimmed_mean_unit.sv
// add: position and fit check plus one deflate pass per width doubling, each
//   pass going through the single bucket read port
// report: total, start and end scans, then the run sum
// clear, unused codes: stay in idle; one item at a time, ready only when idle
// synchronous active-low reset empties the buckets, zeroes base, shift, edges
// and min_shift
module adaptive_histogram_trimmed_mean_unit #(
    parameter int NUM_BUCKETS = ahtm_pkg::DEF_NUM_BUCKETS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ahtm_pkg::SHIFT_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ahtm_pkg::REQ_W-1:0]      i_req_type,
    input  logic [ahtm_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ahtm_pkg::SUM_W-1:0]      o_kept_sum,
    output logic [ahtm_pkg::CNT_W-1:0]      o_kept_count,
    output logic [ahtm_pkg::CNT_W-1:0]      o_total_count,
    output logic [ahtm_pkg::SPAN_W-1:0]     o_span_buckets,
    output logic [ahtm_pkg::SHIFT_W-1:0]    o_width_shift
);

    localparam int IW = $clog2(NUM_BUCKETS);
    localparam int EW = $clog2(NUM_BUCKETS + 1);
    localparam int SW = ahtm_pkg::SUM_W;
    localparam int CW = ahtm_pkg::CNT_W;
    localparam int HW = ahtm_pkg::SHIFT_W;
    localparam int PW = ahtm_pkg::RECIP_W + CW;
    localparam int RECIP = (2 ** ahtm_pkg::RECIP_SHIFT + NUM_BUCKETS - 1) / NUM_BUCKETS;

    localparam logic [EW-1:0] N_E    = EW'(NUM_BUCKETS);
    localparam logic [EW-1:0] N_E1   = EW'(NUM_BUCKETS - 1);
    localparam logic [IW-1:0] N_I1   = IW'(NUM_BUCKETS - 1);
    localparam logic [ahtm_pkg::RECIP_W-1:0] RECIP_C = ahtm_pkg::RECIP_W'(RECIP);

    ahtm_pkg::t_state r_state, n_state;

    logic [SW-1:0] r_base, n_base;
    logic [HW-1:0] r_shift, n_shift;
    logic [EW-1:0] r_upper, n_upper;
    logic [EW-1:0] r_lower, n_lower;
    logic [HW-1:0] r_min_shift, n_min_shift;
    logic          r_out_valid, n_out_valid;

    logic [SW-1:0] r_sample, n_sample;
    logic [SW-1:0] r_pos, n_pos;
    logic [SW-1:0] r_acc_sum, n_acc_sum;
    logic [CW-1:0] r_acc_cnt, n_acc_cnt;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_th, n_th;
    logic [EW-1:0] r_p, n_p;
    logic [IW-1:0] r_w, n_w;
    logic          r_phase, n_phase;
    logic [IW-1:0] r_s, n_s;
    logic [EW-1:0] r_e, n_e;
    logic          r_wrap, n_wrap;
    logic [ahtm_pkg::SPAN_W-1:0] r_span, n_span;
    logic [SW-1:0] r_o_sum, n_o_sum;
    logic [CW-1:0] r_o_cnt, n_o_cnt;
    logic [CW-1:0] r_o_total, n_o_total;
    logic [ahtm_pkg::SPAN_W-1:0] r_o_span, n_o_span;
    logic [HW-1:0] r_o_shift, n_o_shift;

    ahtm_pkg::t_store_ctl st_ctl;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] wr_idx;
    logic [SW-1:0] wr_sum;
    logic [CW-1:0] wr_cnt;
    logic [EW-1:0] clr_lo;
    logic [EW-1:0] clr_hi;
    logic [SW-1:0] rd_sum;
    logic [CW-1:0] rd_cnt;

    logic          in_xfer;
    logic [SW-1:0] diff;
    logic [SW:0]   pos_wrap;
    logic          fit_neg;
    logic          fit_pos;
    logic [IW-1:0] fit_idx;
    logic [EW:0]   up_half;
    logic [EW:0]   lo_half;
    logic [PW-1:0] th_prod;
    logic          cnt_hit;
    logic          out_load;
    logic [EW-1:0] e_sel;
    logic [EW:0]   span_full;

    ahtm_bucket_store #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .IW          (IW),
        .EW          (EW)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (st_ctl),
        .i_rd_idx (rd_idx),
        .o_rd_sum (rd_sum),
        .o_rd_cnt (rd_cnt),
        .i_wr_idx (wr_idx),
        .i_wr_sum (wr_sum),
        .i_wr_cnt (wr_cnt),
        .i_clr_lo (clr_lo),
        .i_clr_hi (clr_hi)
    );

    assign in_xfer  = i_in_valid && o_in_ready;
    assign diff     = r_sample - r_base;
    assign pos_wrap = {r_pos[SW-1], r_pos} + (SW+1)'(NUM_BUCKETS);
    assign fit_neg  = r_pos[SW-1] && !pos_wrap[SW] && (pos_wrap[SW-1:0] >= SW'(r_upper));
    assign fit_pos  = !r_pos[SW-1] && (r_pos < SW'(r_lower));
    assign fit_idx  = r_pos[SW-1] ? pos_wrap[IW-1:0] : r_pos[IW-1:0];
    assign up_half  = ({1'b0, r_upper} + (EW+1)'(1)) >> 1;
    assign lo_half  = ({1'b0, N_E} + {1'b0, r_lower}) >> 1;
    assign th_prod  = PW'(r_total) * PW'(RECIP_C);
    assign cnt_hit  = (rd_cnt >= r_th);
    assign out_load = (r_state == ahtm_pkg::S_OUT) && (!r_out_valid || i_out_ready);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ahtm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_req_type)
                        ahtm_pkg::REQ_ADD:    n_state = ahtm_pkg::S_POS;
                        ahtm_pkg::REQ_REPORT: n_state = ahtm_pkg::S_TOT;
                        default:              n_state = ahtm_pkg::S_IDLE;
                    endcase
                end
            end
            ahtm_pkg::S_POS: n_state = ahtm_pkg::S_FIT;
            ahtm_pkg::S_FIT: begin
                n_state = (fit_neg || fit_pos) ? ahtm_pkg::S_IDLE : ahtm_pkg::S_UP_A;
            end
            ahtm_pkg::S_UP_A: begin
                if (r_p < r_upper) begin
                    n_state = (r_p + EW'(1) < r_upper) ? ahtm_pkg::S_UP_B : ahtm_pkg::S_UP_W;
                end else begin
                    n_state = ahtm_pkg::S_LO_A;
                end
            end
            ahtm_pkg::S_UP_B: n_state = ahtm_pkg::S_UP_A;
            ahtm_pkg::S_UP_W: n_state = ahtm_pkg::S_LO_A;
            ahtm_pkg::S_LO_A: begin
                if (r_p > r_lower) begin
                    n_state = ahtm_pkg::S_LO_B;
                end else begin
                    n_state = r_lower[0] ? ahtm_pkg::S_LO_W : ahtm_pkg::S_FIN;
                end
            end
            ahtm_pkg::S_LO_B: n_state = ahtm_pkg::S_LO_A;
            ahtm_pkg::S_LO_W: n_state = ahtm_pkg::S_FIN;
            ahtm_pkg::S_FIN:  n_state = ahtm_pkg::S_POS;
            ahtm_pkg::S_TOT: begin
                if (r_p == N_E1) begin
                    n_state = ahtm_pkg::S_TH;
                end
            end
            ahtm_pkg::S_TH: n_state = ahtm_pkg::S_ST;
            ahtm_pkg::S_ST: begin
                if (cnt_hit || (r_p == N_E1 && r_phase)) begin
                    n_state = ahtm_pkg::S_EN;
                end
            end
            ahtm_pkg::S_EN: begin
                if (cnt_hit || (r_p == EW'(1) && r_phase)) begin
                    n_state = ahtm_pkg::S_SUM;
                end
            end
            ahtm_pkg::S_SUM: begin
                if (!(r_wrap || r_p < r_e)) begin
                    n_state = ahtm_pkg::S_OUT;
                end
            end
            ahtm_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = ahtm_pkg::S_IDLE;
                end
            end
            default: n_state = ahtm_pkg::S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        n_base      = r_base;
        n_shift     = r_shift;
        n_upper     = r_upper;
        n_lower     = r_lower;
        n_min_shift = r_min_shift;
        n_sample    = r_sample;
        n_pos       = r_pos;
        n_acc_sum   = r_acc_sum;
        n_acc_cnt   = r_acc_cnt;
        n_total     = r_total;
        n_th        = r_th;
        n_p         = r_p;
        n_w         = r_w;
        n_phase     = r_phase;
        n_s         = r_s;
        n_e         = r_e;
        n_wrap      = r_wrap;
        n_span      = r_span;
        n_o_sum     = r_o_sum;
        n_o_cnt     = r_o_cnt;
        n_o_total   = r_o_total;
        n_o_span    = r_o_span;
        n_o_shift   = r_o_shift;
        n_out_valid = r_out_valid && !i_out_ready;
        st_ctl      = '0;
        rd_idx      = r_p[IW-1:0];
        wr_idx      = '0;
        wr_sum      = '0;
        wr_cnt      = '0;
        clr_lo      = '0;
        clr_hi      = '0;
        e_sel       = r_p;
        span_full   = '0;
        o_in_ready  = 1'b0;
        o_cfg_ready = 1'b1;

        if (i_cfg_valid) begin
            n_min_shift = i_cfg_data;
        end

        unique case (r_state)
            ahtm_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer) begin
                    case (i_req_type)
                        ahtm_pkg::REQ_ADD: begin
                            n_sample = i_sample;
                            if (r_upper == '0) begin
                                n_shift = r_min_shift;
                                n_base  = i_sample;
                                n_upper = EW'(1);
                                n_lower = N_E;
                            end
                        end
                        ahtm_pkg::REQ_REPORT: begin
                            n_total = '0;
                            n_p     = '0;
                        end
                        ahtm_pkg::REQ_CLEAR: begin
                            st_ctl.clr_all = 1'b1;
                            n_shift = '0;
                            n_upper = '0;
                            n_lower = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ahtm_pkg::S_POS: begin
                n_pos = $unsigned($signed(diff) >>> r_shift);
            end
            ahtm_pkg::S_FIT: begin
                rd_idx = fit_idx;
                if (fit_neg || fit_pos) begin
                    st_ctl.wr_en = 1'b1;
                    wr_idx = fit_idx;
                    wr_sum = rd_sum + r_sample;
                    wr_cnt = rd_cnt + CW'(1);
                    if (fit_neg && (EW'(fit_idx) < r_lower)) begin
                        n_lower = EW'(fit_idx);
                    end
                    if (fit_pos && (EW'(fit_idx) >= r_upper)) begin
                        n_upper = EW'(fit_idx) + EW'(1);
                    end
                end else begin
                    n_p = '0;
                end
            end
            ahtm_pkg::S_UP_A: begin
                rd_idx = r_p[IW-1:0];
                if (r_p < r_upper) begin
                    n_acc_sum = rd_sum;
                    n_acc_cnt = rd_cnt;
                end else begin
                    n_p = N_E1;
                    n_w = N_I1;
                end
            end
            ahtm_pkg::S_UP_B: begin
                rd_idx = IW'(r_p + EW'(1));
                st_ctl.wr_en = 1'b1;
                wr_idx = IW'(r_p >> 1);
                wr_sum = r_acc_sum + rd_sum;
                wr_cnt = r_acc_cnt + rd_cnt;
                n_p = r_p + EW'(2);
            end
            ahtm_pkg::S_UP_W: begin
                st_ctl.wr_en = 1'b1;
                wr_idx = IW'(r_p >> 1);
                wr_sum = r_acc_sum;
                wr_cnt = r_acc_cnt;
                n_p = N_E1;
                n_w = N_I1;
            end
            ahtm_pkg::S_LO_A: begin
                rd_idx = IW'(r_p - EW'(1));
                n_acc_sum = rd_sum;
                n_acc_cnt = rd_cnt;
            end
            ahtm_pkg::S_LO_B: begin
                rd_idx = r_p[IW-1:0];
                st_ctl.wr_en = 1'b1;
                wr_idx = r_w;
                wr_sum = r_acc_sum + rd_sum;
                wr_cnt = r_acc_cnt + rd_cnt;
                n_p = r_p - EW'(2);
                n_w = r_w - IW'(1);
            end
            ahtm_pkg::S_LO_W: begin
                rd_idx = r_lower[IW-1:0];
                st_ctl.wr_en = 1'b1;
                wr_idx = IW'(lo_half);
                wr_sum = rd_sum;
                wr_cnt = rd_cnt;
            end
            ahtm_pkg::S_FIN: begin
                st_ctl.clr_rng = 1'b1;
                clr_lo  = EW'(up_half);
                clr_hi  = EW'(lo_half);
                n_upper = EW'(up_half);
                n_lower = EW'(lo_half);
                if (r_shift != ahtm_pkg::MAX_SHIFT) begin
                    n_shift = r_shift + HW'(1);
                end
            end
            ahtm_pkg::S_TOT: begin
                rd_idx  = r_p[IW-1:0];
                n_total = r_total + rd_cnt;
                n_p     = r_p + EW'(1);
            end
            ahtm_pkg::S_TH: begin
                n_th = th_prod[ahtm_pkg::RECIP_SHIFT +: CW];
                if (r_lower == N_E) begin
                    n_p     = '0;
                    n_phase = 1'b1;
                end else begin
                    n_p     = r_lower;
                    n_phase = 1'b0;
                end
            end
            ahtm_pkg::S_ST: begin
                rd_idx = r_p[IW-1:0];
                if (cnt_hit || (r_p == N_E1 && r_phase)) begin
                    n_s     = cnt_hit ? r_p[IW-1:0] : '0;
                    n_p     = (r_upper == '0) ? N_E : r_upper;
                    n_phase = (r_upper == '0);
                end else if (r_p == N_E1) begin
                    n_p     = '0;
                    n_phase = 1'b1;
                end else begin
                    n_p = r_p + EW'(1);
                end
            end
            ahtm_pkg::S_EN: begin
                rd_idx = IW'(r_p - EW'(1));
                e_sel  = cnt_hit ? r_p : N_E;
                if (cnt_hit || (r_p == EW'(1) && r_phase)) begin
                    n_e       = e_sel;
                    n_wrap    = (e_sel <= EW'(r_s));
                    span_full = {1'b0, e_sel}
                              + ((e_sel <= EW'(r_s)) ? {1'b0, N_E} : '0)
                              - (EW+1)'(r_s) - (EW+1)'(1);
                    n_span    = span_full[ahtm_pkg::SPAN_W-1:0];
                    n_p       = EW'(r_s);
                    n_acc_sum = '0;
                    n_acc_cnt = '0;
                end else if (r_p == EW'(1)) begin
                    n_p     = N_E;
                    n_phase = 1'b1;
                end else begin
                    n_p = r_p - EW'(1);
                end
            end
            ahtm_pkg::S_SUM: begin
                rd_idx = r_p[IW-1:0];
                if (r_wrap || r_p < r_e) begin
                    n_acc_sum = r_acc_sum + rd_sum;
                    n_acc_cnt = r_acc_cnt + rd_cnt;
                    if (r_wrap && r_p == N_E1) begin
                        n_p    = '0;
                        n_wrap = 1'b0;
                    end else begin
                        n_p = r_p + EW'(1);
                    end
                end
            end
            ahtm_pkg::S_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_o_sum     = r_acc_sum;
                    n_o_cnt     = r_acc_cnt;
                    n_o_total   = r_total;
                    n_o_span    = r_span;
                    n_o_shift   = r_shift;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ahtm_pkg::S_IDLE;
            r_base      <= '0;
            r_shift     <= '0;
            r_upper     <= '0;
            r_lower     <= '0;
            r_min_shift <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_shift     <= n_shift;
            r_upper     <= n_upper;
            r_lower     <= n_lower;
            r_min_shift <= n_min_shift;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_pos     <= n_pos;
        r_acc_sum <= n_acc_sum;
        r_acc_cnt <= n_acc_cnt;
        r_total   <= n_total;
        r_th      <= n_th;
        r_p       <= n_p;
        r_w       <= n_w;
        r_phase   <= n_phase;
        r_s       <= n_s;
        r_e       <= n_e;
        r_wrap    <= n_wrap;
        r_span    <= n_span;
        r_o_sum   <= n_o_sum;
        r_o_cnt   <= n_o_cnt;
        r_o_total <= n_o_total;
        r_o_span  <= n_o_span;
        r_o_shift <= n_o_shift;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kept_sum     = r_o_sum;
    assign o_kept_count   = r_o_cnt;
    assign o_total_count  = r_o_total;
    assign o_span_buckets = r_o_span;
    assign o_width_shift  = r_o_shift;

    // edges stay ordered once the store holds samples
    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ahtm_pkg::S_IDLE && r_upper != '0) |-> (r_upper <= r_lower))
        else $error("upper edge beyond lower edge");

    // the fit check only runs on a non-empty ring
    a_fit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ahtm_pkg::S_FIT) |-> (r_upper != '0 && r_lower != '0))
        else $error("fit check on empty ring");

    // run sum pointer never passes the run end
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ahtm_pkg::S_SUM) |-> (r_e != '0 && (r_wrap || r_p <= r_e)))
        else $error("run sum pointer out of range");

    // a result is only loaded when the output register is free or draining
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ahtm_pkg::S_OUT && r_out_valid && !i_out_ready)
        |=> (r_state == ahtm_pkg::S_OUT))
        else $error("result overwritten before transfer");

endmodule

>>> test/tb_adaptive_histogram_trimmed_mean_unit.sv
module tb_adaptive_histogram_trimmed_mean_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ahtm_pkg::*;

    localparam int NB = DEF_NUM_BUCKETS;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int MAX_SQUEEZE = 64;
    localparam int SETTLE_CYCLES = 400;
    localparam int END_WAIT_CYCLES = 50000;
    localparam int PHASE_ITEMS = 140;
    localparam int N_PHASES = 6;
    localparam int N_DIRECTED = 23;

    typedef struct packed {
        logic [SUM_W-1:0]   kept_sum;
        logic [CNT_W-1:0]   kept_count;
        logic [CNT_W-1:0]   total_count;
        logic [SPAN_W-1:0]  span_buckets;
        logic [SHIFT_W-1:0] width_shift;
    } report_t;

    typedef struct packed {
        logic [REQ_W-1:0]    req;
        logic [SAMPLE_W-1:0] smp;
        logic                fixed;
        report_t             res;
    } directed_row_t;

    localparam report_t NO_REPORT = '0;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [SHIFT_W-1:0]    i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [REQ_W-1:0]      i_req_type = '0;
    logic [SAMPLE_W-1:0]   i_sample = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [SUM_W-1:0]      o_kept_sum;
    logic [CNT_W-1:0]      o_kept_count;
    logic [CNT_W-1:0]      o_total_count;
    logic [SPAN_W-1:0]     o_span_buckets;
    logic [SHIFT_W-1:0]    o_width_shift;

    adaptive_histogram_trimmed_mean_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_sample       (i_sample),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kept_sum     (o_kept_sum),
        .o_kept_count   (o_kept_count),
        .o_total_count  (o_total_count),
        .o_span_buckets (o_span_buckets),
        .o_width_shift  (o_width_shift)
    );

    // histogram mirror
    logic [SUM_W-1:0]   hist_sum [NB];
    logic [CNT_W-1:0]   hist_cnt [NB];
    logic [SAMPLE_W-1:0] hist_base;
    logic [SHIFT_W-1:0] hist_shift;
    int                 hist_hi;
    int                 hist_lo;
    logic [SHIFT_W-1:0] cfg_min_shift;

    report_t pending_reports [$];
    int      mismatch_count = 0;
    int      in_idle_pct = 0;
    int      out_idle_pct = 0;

    int phase_shift [N_PHASES] = '{31, 4, 0, 19, 1, 28};
    int phase_clear [N_PHASES] = '{2, 0, 0, 2, 1, 4};

    directed_row_t directed_rows [N_DIRECTED] = '{
        {REQ_REPORT, 32'h0000_0000, 1'b1, 32'd0, 8'd0, 8'd0, 3'd7, 5'd0},
        {REQ_UNUSED, 32'hFFFF_FFFF, 1'b0, NO_REPORT},
        {REQ_REPORT, 32'hFFFF_FFFF, 1'b1, 32'd0, 8'd0, 8'd0, 3'd7, 5'd0},
        {REQ_ADD,    32'd100,       1'b0, NO_REPORT},
        {REQ_ADD,    32'd103,       1'b0, NO_REPORT},
        {REQ_ADD,    32'd99,        1'b0, NO_REPORT},
        {REQ_REPORT, 32'h0000_0000, 1'b0, NO_REPORT},
        {REQ_ADD,    32'hFFFF_FFFF, 1'b0, NO_REPORT},
        {REQ_ADD,    32'h8000_0000, 1'b0, NO_REPORT},
        {REQ_ADD,    32'h7FFF_FFFF, 1'b0, NO_REPORT},
        {REQ_REPORT, 32'h0000_0000, 1'b0, NO_REPORT},
        {REQ_ADD,    32'h0000_0000, 1'b0, NO_REPORT},
        {REQ_ADD,    32'h5555_5555, 1'b0, NO_REPORT},
        {REQ_ADD,    32'hAAAA_AAAA, 1'b0, NO_REPORT},
        {REQ_REPORT, 32'h0000_0000, 1'b0, NO_REPORT},
        {REQ_CLEAR,  32'h0000_0000, 1'b0, NO_REPORT},
        {REQ_REPORT, 32'h0000_0000, 1'b1, 32'd0, 8'd0, 8'd0, 3'd7, 5'd0},
        {REQ_ADD,    32'hFFFF_FFFF, 1'b0, NO_REPORT},
        {REQ_ADD,    32'h0000_0000, 1'b0, NO_REPORT},
        {REQ_ADD,    32'hFFFF_FFF8, 1'b0, NO_REPORT},
        {REQ_ADD,    32'h0000_0006, 1'b0, NO_REPORT},
        {REQ_REPORT, 32'h0000_0000, 1'b0, NO_REPORT},
        {REQ_CLEAR,  32'hFFFF_FFFF, 1'b0, NO_REPORT}
    };

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("** adaptive_histogram_trimmed_mean_unit: FAILED **");
        $finish;
    end

    function automatic void histogram_clear();
        for (int k = 0; k < NB; k++) begin
            hist_sum[k] = '0;
            hist_cnt[k] = '0;
        end
        hist_shift = '0;
        hist_hi = 0;
        hist_lo = 0;
    endfunction

    function automatic longint bucket_offset(logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] d;
        d = v - hist_base;
        return longint'($signed(d) >>> hist_shift);
    endfunction

    function automatic void merge_pair(int dst, int src);
        hist_sum[dst] = hist_sum[src] + hist_sum[src + 1];
        hist_cnt[dst] = hist_cnt[src] + hist_cnt[src + 1];
    endfunction

    // halve the resolution: neighbouring buckets merge towards the base
    function automatic void histogram_squeeze();
        int a;
        int b;
        b = 0;
        for (a = 0; a + 1 < hist_hi; a += 2) begin
            merge_pair(b, a);
            b++;
        end
        if (hist_hi % 2 == 1) begin
            a = hist_hi - 1;
            hist_sum[a >> 1] = hist_sum[a];
            hist_cnt[a >> 1] = hist_cnt[a];
        end
        b = NB - 1;
        for (a = NB - 1; a - 1 >= hist_lo; a -= 2) begin
            merge_pair(b, a - 1);
            b--;
        end
        if (hist_lo % 2 == 1) begin
            b = (NB + hist_lo) >> 1;
            hist_sum[b] = hist_sum[hist_lo];
            hist_cnt[b] = hist_cnt[hist_lo];
        end
        if (hist_shift < MAX_SHIFT)
            hist_shift++;
        a = (hist_hi + 1) >> 1;
        b = (NB + hist_lo) >> 1;
        for (int k = a; k < b; k++) begin
            hist_sum[k] = '0;
            hist_cnt[k] = '0;
        end
        hist_hi = a;
        hist_lo = b;
    endfunction

    function automatic void histogram_add(logic [SAMPLE_W-1:0] v);
        longint pos;
        bit     fits;
        int     idx;
        pos = 0;
        fits = 1'b0;
        if (hist_hi == 0) begin
            hist_shift = cfg_min_shift;
            hist_base = v;
            hist_hi = 1;
            hist_lo = NB;
        end
        for (int n = 0; n < MAX_SQUEEZE && !fits; n++) begin
            pos = bucket_offset(v);
            if ((pos < 0 && pos + NB >= hist_hi) || (pos >= 0 && pos < hist_lo))
                fits = 1'b1;
            else
                histogram_squeeze();
        end
        if (fits) begin
            if (pos < 0) begin
                idx = int'(pos + NB);
                if (idx < hist_lo)
                    hist_lo = idx;
            end else begin
                idx = int'(pos);
                if (idx >= hist_hi)
                    hist_hi = idx + 1;
            end
            hist_sum[idx] = hist_sum[idx] + v;
            hist_cnt[idx] = hist_cnt[idx] + 8'd1;
        end
    endfunction

    function automatic report_t histogram_report();
        report_t            r;
        logic [CNT_W-1:0]   total;
        logic [CNT_W-1:0]   kept;
        logic [SUM_W-1:0]   sum;
        int                 th;
        int                 s;
        int                 e;
        int                 k;
        int                 span;
        total = '0;
        kept = '0;
        sum = '0;
        for (k = 0; k < NB; k++)
            total = total + hist_cnt[k];
        th = int'(total) / NB;
        s = -1;
        for (k = hist_lo; k < NB && s < 0; k++)
            if (int'(hist_cnt[k]) >= th) s = k;
        for (k = 0; k < NB && s < 0; k++)
            if (int'(hist_cnt[k]) >= th) s = k;
        if (s < 0)
            s = 0;
        e = -1;
        for (k = hist_hi; k > 0 && e < 0; k--)
            if (int'(hist_cnt[k - 1]) >= th) e = k;
        for (k = NB; k > 0 && e < 0; k--)
            if (int'(hist_cnt[k - 1]) >= th) e = k;
        if (e < 0)
            e = NB;
        span = e - s - 1;
        k = s;
        if (e <= s) begin
            for (; k < NB; k++) begin
                kept = kept + hist_cnt[k];
                sum = sum + hist_sum[k];
            end
            k = 0;
            span += NB;
        end
        for (; k < e; k++) begin
            kept = kept + hist_cnt[k];
            sum = sum + hist_sum[k];
        end
        r.kept_sum = sum;
        r.kept_count = kept;
        r.total_count = total;
        r.span_buckets = span[SPAN_W-1:0];
        r.width_shift = hist_shift;
        return r;
    endfunction

    task automatic send_request(input logic [REQ_W-1:0] req, input logic [SAMPLE_W-1:0] smp,
                                input logic fixed, input report_t fixed_res);
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_sample <= smp;
        do @(posedge i_clk); while (!o_in_ready);
        case (req)
            REQ_ADD:    histogram_add(smp);
            REQ_REPORT: pending_reports.push_back(fixed ? fixed_res : histogram_report());
            REQ_CLEAR:  histogram_clear();
            default: ;
        endcase
    endtask

    task automatic drain_reports();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    task automatic write_min_shift(input logic [SHIFT_W-1:0] v);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_min_shift = v;
    endtask

    always @(posedge i_clk) begin : report_check
        report_t got;
        report_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_kept_sum, o_kept_count, o_total_count, o_span_buckets, o_width_shift};
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: sum %h kept %0d total %0d span %0d shift %0d",
                             got.kept_sum, got.kept_count, got.total_count,
                             got.span_buckets, got.width_shift);
            end else begin
                want = pending_reports.pop_front();
                if (got.kept_sum !== want.kept_sum || got.kept_count !== want.kept_count ||
                    got.total_count !== want.total_count ||
                    got.span_buckets !== want.span_buckets ||
                    got.width_shift !== want.width_shift) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp sum %h kept %0d total %0d span %0d shift %0d, got sum %h kept %0d total %0d span %0d shift %0d",
                                 want.kept_sum, want.kept_count, want.total_count,
                                 want.span_buckets, want.width_shift,
                                 got.kept_sum, got.kept_count, got.total_count,
                                 got.span_buckets, got.width_shift);
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    initial begin
        logic [REQ_W-1:0]    req;
        logic [SAMPLE_W-1:0] smp;
        logic [SAMPLE_W-1:0] center;
        logic [SAMPLE_W-1:0] mask;
        int                  roll;
        int                  waited;
        histogram_clear();
        hist_base = '0;
        cfg_min_shift = '0;
        in_idle_pct = 37;
        out_idle_pct = 51;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_min_shift(5'd0);

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_rows[i].req, directed_rows[i].smp,
                         directed_rows[i].fixed, directed_rows[i].res);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 2) begin
                in_idle_pct = 51;
                out_idle_pct = 37;
            end else if (p == 4) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end
            write_min_shift(phase_shift[p][SHIFT_W-1:0]);
            center = $urandom;
            mask = (cfg_min_shift >= 5'd27) ? 32'hFFFF_FFFF : ((32'd32 << cfg_min_shift) - 32'd1);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 0 && i == 70)
                    drain_reports();
                roll = $urandom_range(99);
                smp = $urandom;
                if (roll < 2)
                    req = REQ_UNUSED;
                else if (roll < 2 + phase_clear[p])
                    req = REQ_CLEAR;
                else if (roll < 14 + phase_clear[p])
                    req = REQ_REPORT;
                else begin
                    req = REQ_ADD;
                    roll = $urandom_range(9);
                    if (roll < 6)
                        smp = center + ($urandom & mask) - (mask >> 1);
                    else if (roll < 8)
                        smp = center + $urandom_range(15);
                end
                send_request(req, smp, 1'b0, NO_REPORT);
            end
        end

        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < END_WAIT_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("** adaptive_histogram_trimmed_mean_unit: PASSED **");
        else
            $display("** adaptive_histogram_trimmed_mean_unit: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ahtm_pkg.sv
rtl/ahtm_bucket_store.sv
rtl/adaptive_histogram_trimmed_mean_unit.sv
test/tb_adaptive_histogram_trimmed_mean_unit.sv
